// ===== hw/rtl/lnod_pkg.sv =====
// ----------------------------------------------------------------------------
// lnod_pkg
// Shared constants and types of the lidar nearest-obstacle deflection block.
// ----------------------------------------------------------------------------
`default_nettype none

package lnod_pkg;

  // default width of a range sample
  localparam int RANGE_BITS_DEF = 16;

  // Q3.13 angle constants
  localparam int Q_PI          = 25736;
  localparam int Q_HALF_PI     = 12868;
  localparam int Q_TAU         = 51472;
  localparam int Q_3PI4        = 19302;
  localparam int MM_PER_CM     = 10;

  localparam int ANGLE_W       = 16;
  localparam int THRESH_W      = 13;
  localparam int LIMIT_W       = 16;
  localparam int MAG_W         = 15;

  // shared divider: numerator covers threshold times 3pi/4
  localparam int DIV_NUM_W     = THRESH_W + MAG_W;
  localparam int DIV_DEN_W     = THRESH_W;
  localparam int STEP_W        = $clog2(DIV_NUM_W + 1);

  // configuration register indexes
  localparam int CFG_IDX_W     = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_INC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd4;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [STEP_W-1:0]    steps;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lnod_div.sv =====
// ----------------------------------------------------------------------------
// lnod_div
// Restoring divider, one quotient bit per cycle, numerator MSB-aligned.
// ----------------------------------------------------------------------------
`default_nettype none

module lnod_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lnod_pkg::div_cmd_t            cmd,
  output lnod_pkg::div_stat_t                stat,
  output logic [lnod_pkg::DIV_NUM_W-1:0]     quotient
);

  localparam int NW = lnod_pkg::DIV_NUM_W;
  localparam int DW = lnod_pkg::DIV_DEN_W;
  localparam int SW = lnod_pkg::STEP_W;

  logic [NW-1:0] num_r, num_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, num_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      num_nxt  = cmd.num;
      den_nxt  = cmd.den;
      quo_nxt  = '0;
      rem_nxt  = '0;
      cnt_nxt  = cmd.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], 1'b0};
      quo_nxt = {quo_r[NW-2:0], fits};
      rem_nxt = fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      cnt_nxt = cnt_r - SW'(1);
      if (cnt_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !cmd.start && den_r != '0 |=> rem_r < den_r)
    else $error("divider remainder not below divisor");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without preceding busy cycle");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == SW'(1) && !cmd.start |=> !busy_r && done_r)
    else $error("divider did not finish on final step");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lidar_nearest_obstacle_deflection.sv =====
// ----------------------------------------------------------------------------
// lidar_nearest_obstacle_deflection
// Tracks the nearest kept lidar sample of a scan and emits a steering
// deflection on the last sample.
// ----------------------------------------------------------------------------
//
// channel  direction  handshake             payload
// in_      input      in_valid/in_ready     in_range_mm, in_is_finite, in_last
// out_     output     out_valid/out_ready   out_deflection, out_obstacle_seen
// cfg_     input      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// a sample is converted mm/10 by reciprocal multiply on accept, then goes to
// the nearest compare; in_ready is high only while idle
// a last sample then has one multiply, 28 divider steps for the deflection (none
// if no kept sample is below threshold), then the hand-over to the output register
// rst_n (synchronous) restores register defaults and clears the scan state
// a pending result does not block input; only a second result waits for it
// cfg_ready is always high
//
`default_nettype none

module lidar_nearest_obstacle_deflection #(
  parameter int RANGE_BITS = lnod_pkg::RANGE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [RANGE_BITS-1:0]               in_range_mm,
  input  wire logic                                in_is_finite,
  input  wire logic                                in_last,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [lnod_pkg::ANGLE_W-1:0]      out_deflection,
  output logic                                     out_obstacle_seen,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lnod_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lnod_pkg::LIMIT_W-1:0]        cfg_data
);

  localparam int AW      = lnod_pkg::ANGLE_W;
  localparam int TW      = lnod_pkg::THRESH_W;
  localparam int LW      = lnod_pkg::LIMIT_W;
  localparam int NW      = lnod_pkg::DIV_NUM_W;
  localparam int MW      = lnod_pkg::MAG_W;
  localparam int SW      = lnod_pkg::STEP_W;
  localparam int XW      = AW + 3;
  localparam int CM_BITS = RANGE_BITS - 3;
  localparam int RW      = (RANGE_BITS > LW) ? RANGE_BITS : LW;
  localparam int CW      = (CM_BITS > TW) ? CM_BITS : TW;

  // ceil(2^(RANGE_BITS+3) / 10): exact mm/10 for every RANGE_BITS-wide range
  localparam int CM_SHIFT = RANGE_BITS + 3;
  localparam int PW       = 2 * RANGE_BITS + 1;
  localparam int CM_RECIP = ((1 << CM_SHIFT) + lnod_pkg::MM_PER_CM - 1)
                            / lnod_pkg::MM_PER_CM;

  localparam logic signed [XW-1:0] X_PI   = XW'(lnod_pkg::Q_PI);
  localparam logic signed [XW-1:0] X_HALF = XW'(lnod_pkg::Q_HALF_PI);
  localparam logic signed [XW-1:0] X_TAU  = XW'(lnod_pkg::Q_TAU);
  localparam logic signed [XW-1:0] X_TAU2 = XW'(2 * lnod_pkg::Q_TAU);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CM   = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic signed [AW-1:0] start_angle_r;
  logic signed [AW-1:0] angle_inc_r;
  logic [LW-1:0]        min_range_r;
  logic [LW-1:0]        max_range_r;
  logic [TW-1:0]        threshold_r;

  // scan state
  logic [AW-1:0]        angle_offset_r, angle_offset_nxt;
  logic [CM_BITS-1:0]   nearest_cm_r, nearest_cm_nxt;
  logic signed [AW-1:0] nearest_angle_r, nearest_angle_nxt;
  logic                 have_r, have_nxt;

  // sample held for the compare cycle
  logic                 keep_r, keep_nxt;
  logic                 last_r, last_nxt;
  logic signed [AW-1:0] angle_r, angle_nxt;
  logic [CM_BITS-1:0]   cm_r, cm_nxt;

  logic signed [AW-1:0] res_defl_r, res_defl_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [AW-1:0] out_defl_r, out_defl_nxt;
  logic                 out_seen_r, out_seen_nxt;

  lnod_pkg::div_cmd_t   div_cmd;
  lnod_pkg::div_stat_t  div_stat;
  logic [NW-1:0]        div_quo;

  // beam angle
  logic signed [XW-1:0] x_raw, x_wrap, angle_full;
  logic signed [XW-1:0] inc_mod, off_sum;
  logic                 angle_ok, range_ok;
  logic [RW-1:0]        rng_w, min_w, max_w;

  logic                 in_acc;
  logic [PW-1:0]        cm_prod;
  logic [CM_BITS-1:0]   cm_calc;
  logic [CW-1:0]        near_w, thr_w, diff_w;
  logic [NW-1:0]        product;
  logic [MW-1:0]        mag;

  assign in_acc = in_valid && in_ready;

  always_comb begin
    x_raw = X_TAU - XW'(start_angle_r) + $signed(XW'(angle_offset_r));
    if (x_raw >= X_TAU2) begin
      x_wrap = x_raw - X_TAU2;
    end else if (x_raw >= X_TAU) begin
      x_wrap = x_raw - X_TAU;
    end else begin
      x_wrap = x_raw;
    end
    angle_full = X_PI - x_wrap;
    angle_ok   = (angle_full >= -X_HALF) && (angle_full <= X_HALF);

    inc_mod = XW'(angle_inc_r);
    if (inc_mod < 0) begin
      inc_mod = inc_mod + X_TAU;
    end
    off_sum = $signed(XW'(angle_offset_r)) + inc_mod;
    if (off_sum >= X_TAU) begin
      off_sum = off_sum - X_TAU;
    end

    rng_w    = RW'(in_range_mm);
    min_w    = RW'(min_range_r);
    max_w    = RW'(max_range_r);
    range_ok = (rng_w >= min_w) && (rng_w <= max_w);
  end

  assign cm_prod = PW'(in_range_mm) * PW'(CM_RECIP);
  assign cm_calc = cm_prod[CM_SHIFT +: CM_BITS];
  assign near_w  = CW'(nearest_cm_r);
  assign thr_w   = CW'(threshold_r);
  assign diff_w  = thr_w - near_w;
  assign product = NW'(diff_w[TW-1:0]) * NW'(lnod_pkg::Q_3PI4);
  assign mag     = div_quo[MW-1:0];

  always_comb begin
    state_nxt         = state_r;
    angle_offset_nxt  = angle_offset_r;
    nearest_cm_nxt    = nearest_cm_r;
    nearest_angle_nxt = nearest_angle_r;
    have_nxt          = have_r;
    keep_nxt          = keep_r;
    last_nxt          = last_r;
    angle_nxt         = angle_r;
    cm_nxt            = cm_r;
    res_defl_nxt      = res_defl_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_defl_nxt      = out_defl_r;
    out_seen_nxt      = out_seen_r;
    div_cmd.start     = 1'b0;
    div_cmd.num       = product;
    div_cmd.den       = threshold_r;
    div_cmd.steps     = SW'(NW);
    in_ready          = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          keep_nxt         = in_is_finite && range_ok && angle_ok;
          last_nxt         = in_last;
          angle_nxt        = angle_full[AW-1:0];
          cm_nxt           = cm_calc;
          angle_offset_nxt = off_sum[AW-1:0];
          state_nxt        = S_CM;
        end
      end
      S_CM: begin
        // first minimum wins ties
        if (keep_r && (!have_r || cm_r < nearest_cm_r)) begin
          nearest_cm_nxt    = cm_r;
          nearest_angle_nxt = angle_r;
          have_nxt          = 1'b1;
        end
        state_nxt = last_r ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        if (have_r && near_w < thr_w) begin
          div_cmd.start = 1'b1;
          div_cmd.num   = product;
          div_cmd.den   = threshold_r;
          div_cmd.steps = SW'(NW);
          state_nxt     = S_DIV;
        end else begin
          res_defl_nxt = '0;
          state_nxt    = S_OUT;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_defl_nxt = (nearest_angle_r > 0) ? -$signed(AW'(mag)) : $signed(AW'(mag));
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_defl_nxt      = res_defl_r;
          out_seen_nxt      = have_r;
          angle_offset_nxt  = '0;
          nearest_cm_nxt    = '0;
          nearest_angle_nxt = '0;
          have_nxt          = 1'b0;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      start_angle_r   <= AW'(-lnod_pkg::Q_PI);
      angle_inc_r     <= '0;
      min_range_r     <= '0;
      max_range_r     <= '1;
      threshold_r     <= TW'(100);
      angle_offset_r  <= '0;
      nearest_cm_r    <= '0;
      nearest_angle_r <= '0;
      have_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      angle_offset_r  <= angle_offset_nxt;
      nearest_cm_r    <= nearest_cm_nxt;
      nearest_angle_r <= nearest_angle_nxt;
      have_r          <= have_nxt;
      out_valid_r     <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          lnod_pkg::CFG_START_ANGLE: start_angle_r <= $signed(cfg_data);
          lnod_pkg::CFG_ANGLE_INC:   angle_inc_r   <= $signed(cfg_data);
          lnod_pkg::CFG_MIN_RANGE:   min_range_r   <= cfg_data;
          lnod_pkg::CFG_MAX_RANGE:   max_range_r   <= cfg_data;
          lnod_pkg::CFG_THRESHOLD:   threshold_r   <= cfg_data[TW-1:0];
          default: begin
          end
        endcase
      end
    end
    keep_r     <= keep_nxt;
    last_r     <= last_nxt;
    angle_r    <= angle_nxt;
    cm_r       <= cm_nxt;
    res_defl_r <= res_defl_nxt;
    out_defl_r <= out_defl_nxt;
    out_seen_r <= out_seen_nxt;
  end

  lnod_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_deflection    = out_defl_r;
  assign out_obstacle_seen = out_seen_r;

`ifndef SYNTHESIS
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !div_stat.busy)
    else $error("divider busy while waiting for a sample");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_CM || state_r == S_DIV))
    else $error("divider result arrived outside a waiting state");
  a_offset_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> angle_offset_r < AW'(lnod_pkg::Q_TAU))
    else $error("angle offset not reduced below tau");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_seen_r |-> out_defl_r == '0)
    else $error("deflection on a scan with no kept sample");
  a_defl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_defl_r <= AW'(lnod_pkg::Q_3PI4))
                    && (out_defl_r >= -AW'(lnod_pkg::Q_3PI4)))
    else $error("deflection outside three quarter pi");
`endif

endmodule

`default_nettype wire

// ===== tb/lidar_nearest_obstacle_deflection_tb.sv =====
// ----------------------------------------------------------------------------
// lidar_nearest_obstacle_deflection_tb
// Streams lidar scans into the block under bursty input and a stalling output,
// predicts the deflection of each scan and checks every result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_nearest_obstacle_deflection_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RB           = lnod_pkg::RANGE_BITS_DEF;
  localparam int SETTLE       = 64;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RAND_PHASES  = 14;
  localparam int PHASE_ITEMS  = 85;
  localparam int SHOWN_ERRORS = 10;
  // index with no register behind it, writes are dropped
  localparam logic [lnod_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  typedef struct packed {
    logic [RB-1:0] rng_mm;
    logic          fin;
    logic          lst;
  } lidar_beam_t;

  typedef struct {
    logic signed [lnod_pkg::ANGLE_W-1:0] defl;
    logic                                seen;
  } steer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [RB-1:0] in_range_mm = '0;
  logic in_is_finite = 1'b0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [lnod_pkg::ANGLE_W-1:0] out_deflection;
  logic out_obstacle_seen;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lnod_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lnod_pkg::LIMIT_W-1:0] cfg_data = '0;

  lidar_nearest_obstacle_deflection #(.RANGE_BITS(RB)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_range_mm(in_range_mm), .in_is_finite(in_is_finite), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_deflection(out_deflection), .out_obstacle_seen(out_obstacle_seen),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers and the scan state
  logic signed [lnod_pkg::ANGLE_W-1:0]  start_ang;
  logic signed [lnod_pkg::ANGLE_W-1:0]  step_ang;
  logic [lnod_pkg::LIMIT_W-1:0]         min_mm;
  logic [lnod_pkg::LIMIT_W-1:0]         max_mm;
  logic [lnod_pkg::THRESH_W-1:0]        thresh_cm;
  logic [lnod_pkg::ANGLE_W-1:0]         scan_offset;
  logic [lnod_pkg::THRESH_W-1:0]        nearest_cm;
  logic signed [lnod_pkg::ANGLE_W-1:0]  nearest_ang;
  logic                                 have_nearest;

  lidar_beam_t beam_q[$];
  steer_t      steer_q[$];
  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;

  function automatic int wrap_tau(input int a);
    int r;
    r = a % lnod_pkg::Q_TAU;
    return (r < 0) ? r + lnod_pkg::Q_TAU : r;
  endfunction

  function automatic void clear_scan();
    scan_offset  = '0;
    nearest_cm   = '0;
    nearest_ang  = '0;
    have_nearest = 1'b0;
  endfunction

  function automatic void reset_registers();
    start_ang = 16'(-lnod_pkg::Q_PI);
    step_ang  = '0;
    min_mm    = '0;
    max_mm    = 16'hFFFF;
    thresh_cm = 13'd100;
    clear_scan();
  endfunction

  function automatic void apply_reg(input logic [lnod_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [lnod_pkg::LIMIT_W-1:0] val);
    case (idx)
      lnod_pkg::CFG_START_ANGLE: start_ang = val;
      lnod_pkg::CFG_ANGLE_INC:   step_ang  = val;
      lnod_pkg::CFG_MIN_RANGE:   min_mm    = val;
      lnod_pkg::CFG_MAX_RANGE:   max_mm    = val;
      lnod_pkg::CFG_THRESHOLD:   thresh_cm = val[lnod_pkg::THRESH_W-1:0];
      default: ;
    endcase
  endfunction

  // one beam into the nearest-obstacle tracker; on a last beam the steer is queued
  function automatic void track_beam(input lidar_beam_t b);
    int ang;
    int cm;
    int mag;
    bit keep;
    steer_t s;
    ang = -(wrap_tau(lnod_pkg::Q_PI - int'(start_ang) + int'(scan_offset)
                     + lnod_pkg::Q_PI) - lnod_pkg::Q_PI);
    keep = b.fin && (b.rng_mm >= min_mm) && (b.rng_mm <= max_mm) &&
           (ang >= -lnod_pkg::Q_HALF_PI) && (ang <= lnod_pkg::Q_HALF_PI);
    if (keep) begin
      cm = int'(b.rng_mm) / lnod_pkg::MM_PER_CM;
      if (!have_nearest || cm < int'(nearest_cm)) begin
        nearest_cm   = cm[lnod_pkg::THRESH_W-1:0];
        nearest_ang  = ang[lnod_pkg::ANGLE_W-1:0];
        have_nearest = 1'b1;
      end
    end
    scan_offset = 16'(wrap_tau(int'(scan_offset) + wrap_tau(int'(step_ang))));
    if (b.lst) begin
      mag = 0;
      if (have_nearest && nearest_cm < thresh_cm) begin
        mag = ((int'(thresh_cm) - int'(nearest_cm)) * lnod_pkg::Q_3PI4)
              / int'(thresh_cm);
        if (nearest_ang > 0) mag = -mag;
      end
      s.defl = 16'(mag);
      s.seen = have_nearest;
      steer_q.insert(steer_q.size(), s);
      clear_scan();
    end
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_cnt++;
    if (mismatch_cnt <= SHOWN_ERRORS)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  // driver: bursts of beams with random gaps in between
  int burst_left = 0;
  int gap_left = 0;
  lidar_beam_t nxt_beam;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        nxt_beam.rng_mm = in_range_mm;
        nxt_beam.fin    = in_is_finite;
        nxt_beam.lst    = in_last;
        track_beam(nxt_beam);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (beam_q.size() != 0) begin
          nxt_beam = beam_q.pop_front();
          in_valid     <= 1'b1;
          in_range_mm  <= nxt_beam.rng_mm;
          in_is_finite <= nxt_beam.fin;
          in_last      <= nxt_beam.lst;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: output stalls follow a ready rate that changes every so often
  int ready_pct = 100;
  int rate_left = 0;

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (steer_q.size() == 0) begin
        note_mismatch("result with nothing pending", 0, 1);
      end else begin
        steer_t want;
        want = steer_q.pop_front();
        if (out_deflection !== want.defl)
          note_mismatch("deflection", int'(want.defl), int'(out_deflection));
        if (out_obstacle_seen !== want.seen)
          note_mismatch("obstacle_seen", int'(want.seen), int'(out_obstacle_seen));
      end
    end
    if (rate_left <= 0) begin
      case ($urandom_range(0, 4))
        0, 1: ready_pct = 100;
        2:    ready_pct = 60;
        3:    ready_pct = 25;
        default: ready_pct = 5;
      endcase
      rate_left = $urandom_range(50, 300);
    end
    rate_left--;
    out_ready <= rst_n && ($urandom_range(0, 99) < ready_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_beam(input int rng, input bit fin, input bit lst);
    lidar_beam_t b;
    b.rng_mm = rng[RB-1:0];
    b.fin    = fin;
    b.lst    = lst;
    beam_q.insert(beam_q.size(), b);
  endtask

  task automatic write_reg(input logic [lnod_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[lnod_pkg::LIMIT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val[lnod_pkg::LIMIT_W-1:0]);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until every scan result is back and the block has gone quiet
  task automatic wait_idle();
    do @(posedge clk); while (beam_q.size() != 0 || in_valid || steer_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stim
    int p;
    int n;
    int len;
    int k;
    int lim;
    int rng;
    reset_registers();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: every beam sits at angle zero
    queue_beam(0, 1'b0, 1'b1);          // empty scan
    queue_beam(65535, 1'b1, 1'b0);
    queue_beam(0, 1'b1, 1'b1);          // closest possible obstacle
    queue_beam(2000, 1'b1, 1'b1);       // beyond threshold
    queue_beam(509, 1'b1, 1'b0);
    queue_beam(500, 1'b1, 1'b0);        // same cm as the first, first wins
    queue_beam(990, 1'b1, 1'b1);
    wait_idle();

    // quarter-pi sweep from pi downwards, both half-pi edges included
    write_reg(lnod_pkg::CFG_START_ANGLE, 0);
    write_reg(lnod_pkg::CFG_ANGLE_INC, lnod_pkg::Q_PI / 4);
    write_reg(lnod_pkg::CFG_MIN_RANGE, 0);
    write_reg(lnod_pkg::CFG_MAX_RANGE, 65535);
    write_reg(lnod_pkg::CFG_THRESHOLD, 6554);
    write_reg(CFG_SPARE_IDX, 16'hFFFF);
    end_writes();
    queue_beam(10, 1'b1, 1'b0);         // negates to pi, out of view
    queue_beam(10, 1'b1, 1'b0);
    queue_beam(3000, 1'b1, 1'b0);
    queue_beam(4000, 1'b1, 1'b0);
    queue_beam(3000, 1'b1, 1'b0);
    queue_beam(5000, 1'b1, 1'b0);
    queue_beam(3500, 1'b1, 1'b0);
    queue_beam(10, 1'b1, 1'b1);
    wait_idle();

    // zero threshold
    write_reg(lnod_pkg::CFG_START_ANGLE, -lnod_pkg::Q_PI);
    write_reg(lnod_pkg::CFG_ANGLE_INC, 0);
    write_reg(lnod_pkg::CFG_THRESHOLD, 0);
    end_writes();
    queue_beam(50, 1'b1, 1'b1);
    wait_idle();

    // inverted limits
    write_reg(lnod_pkg::CFG_MIN_RANGE, 5000);
    write_reg(lnod_pkg::CFG_MAX_RANGE, 4000);
    write_reg(lnod_pkg::CFG_THRESHOLD, 1);
    end_writes();
    queue_beam(4500, 1'b1, 1'b0);
    queue_beam(4500, 1'b1, 1'b1);
    wait_idle();

    // top extremes of the limits and angles
    write_reg(lnod_pkg::CFG_START_ANGLE, lnod_pkg::Q_PI);
    write_reg(lnod_pkg::CFG_ANGLE_INC, -lnod_pkg::Q_PI);
    write_reg(lnod_pkg::CFG_MIN_RANGE, 65535);
    write_reg(lnod_pkg::CFG_MAX_RANGE, 65535);
    end_writes();
    queue_beam(5, 1'b1, 1'b1);
    queue_beam(65535, 1'b1, 1'b1);
    wait_idle();

    for (p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: write_reg(lnod_pkg::CFG_START_ANGLE, -lnod_pkg::Q_PI);
        1: write_reg(lnod_pkg::CFG_START_ANGLE, lnod_pkg::Q_PI);
        default: write_reg(lnod_pkg::CFG_START_ANGLE,
                           int'($urandom_range(0, 2 * lnod_pkg::Q_PI)) - lnod_pkg::Q_PI);
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(lnod_pkg::CFG_ANGLE_INC, -lnod_pkg::Q_PI);
        1: write_reg(lnod_pkg::CFG_ANGLE_INC, lnod_pkg::Q_PI);
        2: write_reg(lnod_pkg::CFG_ANGLE_INC, int'($urandom_range(0, 2000)) - 1000);
        default: write_reg(lnod_pkg::CFG_ANGLE_INC,
                           int'($urandom_range(0, 2 * lnod_pkg::Q_PI)) - lnod_pkg::Q_PI);
      endcase
      case ($urandom_range(0, 7))
        6: begin
          write_reg(lnod_pkg::CFG_MIN_RANGE, $urandom_range(0, 65535));
          write_reg(lnod_pkg::CFG_MAX_RANGE, $urandom_range(0, 65535));
        end
        7: begin
          write_reg(lnod_pkg::CFG_MIN_RANGE, $urandom_range(0, 500));
          write_reg(lnod_pkg::CFG_MAX_RANGE, $urandom_range(1000, 65535));
        end
        default: begin
          write_reg(lnod_pkg::CFG_MIN_RANGE, 0);
          write_reg(lnod_pkg::CFG_MAX_RANGE, 65535);
        end
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(lnod_pkg::CFG_THRESHOLD, 1);
        1: write_reg(lnod_pkg::CFG_THRESHOLD, 6554);
        2: write_reg(lnod_pkg::CFG_THRESHOLD, 0);
        default: write_reg(lnod_pkg::CFG_THRESHOLD, $urandom_range(1, 6554));
      endcase
      end_writes();

      lim = int'(thresh_cm) * 20 + 20;
      if (lim > 65535) lim = 65535;
      n = 0;
      while (n < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
          case ($urandom_range(0, 9))
            0, 1: rng = $urandom_range(0, 65535);
            2:    rng = 0;
            default: rng = $urandom_range(0, lim);
          endcase
          queue_beam(rng, $urandom_range(0, 15) != 0, k == len - 1);
        end
        n += len;
      end
      wait_idle();
    end

    if (mismatch_cnt == 0 && steer_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
